// ===== design/tlfs_pkg.sv =====
package tlfs_pkg;

    // Widths fixed by the item format
    localparam int ID_W    = 4;
    localparam int SLICE_W = 16;
    localparam int FUNC_W  = 3;

    // Event selector codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD_READY  = 3'd0,
        FN_FINISHED   = 3'd1,
        FN_BLOCKED    = 3'd2,
        FN_NOTIFY_ONE = 3'd3,
        FN_NOTIFY_ALL = 3'd4,
        FN_TICK       = 3'd5
    } func_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FIRST_SLICE  = 2'd0,
        CFG_SECOND_SLICE = 2'd1,
        CFG_TICK_INC     = 2'd2
    } cfg_idx_t;

    // Queue selectors into the shared FIFO memory
    typedef logic [1:0] queue_t;
    localparam queue_t Q_HIGH = 2'd0;
    localparam queue_t Q_LOW  = 2'd1;
    localparam queue_t Q_WAIT = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DISP   = 6'b000010,
        ST_POP    = 6'b000100,
        ST_WAITRD = 6'b001000,
        ST_THR    = 6'b010000,
        ST_REPORT = 6'b100000
    } state_t;

endpackage

// ===== design/two_level_feedback_scheduler_top.sv =====
// Channel   | Dir | Signals                                  | Contents
// ----------+-----+------------------------------------------+-------------------------------
// s_*       | in  | s_tvalid s_tready s_tdata s_tuser         | one scheduling event
// m_*       | out | m_tvalid m_tready m_tdata                 | running thread after the event
// cfg_*     | in  | cfg_valid cfg_ready cfg_index cfg_data    | slice / tick register writes
//
// A tick reads the thread memory, then may push the running thread and read the FIFO memory
// for the dispatch. The FIFO and thread memories both have registered reads.
// Reset is asynchronous, active low: idle runs, all FIFOs empty, slices zero. Memories
// are not cleared; fill counts guard the FIFOs and a thread entry is written on add ready.
// One event at a time; s_tready is high only in the idle state. A result waiting on
// m_tready holds the sequencer in its report step. cfg_ready is always high.
module two_level_feedback_scheduler_top #(
    parameter int NUM_THREADS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // event transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [3:0] thread_id, [7:4] zero
    input  logic [2:0]  s_tuser,    // [2:0] func
    // result transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [3:0] running_thread, [4] is_idle,
                                    // [5] queue_overflow, [7:6] zero
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW     = $clog2(NUM_THREADS);       // FIFO slot / thread index
    localparam int TW     = IW + 1;                     // slot sum before wrap
    localparam int CW     = $clog2(NUM_THREADS + 1);    // fill count
    localparam int FDEPTH = 3 * (2 ** IW);              // three FIFOs in one memory
    localparam int SW     = tlfs_pkg::SLICE_W;

    localparam logic [CW-1:0] FULL_CNT  = CW'(NUM_THREADS);
    localparam logic [TW-1:0] WRAP      = TW'(NUM_THREADS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_THREADS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tlfs_pkg::state_t state_reg, state_next;

    logic [tlfs_pkg::ID_W-1:0] running_reg, running_next;
    logic                      idle_reg, idle_next;
    logic                      ovf_reg, ovf_next;
    logic                      all_reg, all_next;     // notify all in progress

    logic [SW-1:0] first_reg, second_reg, inc_reg;

    logic [IW-1:0] head_reg  [3];
    logic [IW-1:0] head_next [3];
    logic [CW-1:0] count_reg  [3];
    logic [CW-1:0] count_next [3];

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;

    // Memories: FIFO store addressed {queue, slot}; thread store {elapsed, limit}
    logic [tlfs_pkg::ID_W-1:0] fifo_mem [FDEPTH];
    logic [tlfs_pkg::ID_W-1:0] fifo_rdata_reg;
    logic [2*SW-1:0]           thr_mem [NUM_THREADS];
    logic [2*SW-1:0]           thr_rdata_reg;

    // ------------------------------------------------------------------
    // Control signals
    // ------------------------------------------------------------------
    logic                      accept;
    tlfs_pkg::func_t           in_func;
    logic [tlfs_pkg::ID_W-1:0] in_tid;
    logic                      tid_ok, wait_id_ok;

    logic                      push_en, push_ok, push_full;
    tlfs_pkg::queue_t          push_q;
    logic [tlfs_pkg::ID_W-1:0] push_id;
    logic [IW-1:0]             push_slot;
    logic                      pop_en;
    tlfs_pkg::queue_t          pop_q;
    logic [IW-1:0]             pop_slot;

    logic                      thr_we;
    logic [IW-1:0]             thr_waddr, run_idx;
    logic [2*SW-1:0]           thr_wdata;

    logic [2:0]                full_vec;
    logic [TW-1:0]             tail_sum [3];
    logic [IW-1:0]             tail_slot [3];

    logic [SW-1:0]             thr_elapsed, thr_limit;
    logic [SW:0]               tick_sum;
    logic                      load_out;

    assign s_tready  = (state_reg == tlfs_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_func   = tlfs_pkg::func_t'(s_tuser);
    assign in_tid    = s_tdata[3:0];
    assign tid_ok    = 32'(in_tid) < 32'(NUM_THREADS);
    assign wait_id_ok = 32'(fifo_rdata_reg) < 32'(NUM_THREADS);
    assign run_idx   = IW'(running_reg);

    assign thr_elapsed = thr_rdata_reg[2*SW-1:SW];
    assign thr_limit   = thr_rdata_reg[SW-1:0];
    assign tick_sum    = {1'b0, thr_elapsed} + {1'b0, inc_reg};

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Per-queue tail slot and full flag
    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            full_vec[q]  = (count_reg[q] == FULL_CNT);
            tail_sum[q]  = TW'(head_reg[q]) + TW'(count_reg[q]);
            tail_slot[q] = (tail_sum[q] >= WRAP) ? IW'(tail_sum[q] - WRAP)
                                                 : IW'(tail_sum[q]);
        end
    end

    always_comb
    begin
        unique case (push_q)
            tlfs_pkg::Q_HIGH:
            begin
                push_full = full_vec[0];
                push_slot = tail_slot[0];
            end
            tlfs_pkg::Q_LOW:
            begin
                push_full = full_vec[1];
                push_slot = tail_slot[1];
            end
            tlfs_pkg::Q_WAIT:
            begin
                push_full = full_vec[2];
                push_slot = tail_slot[2];
            end
            default:
            begin
                push_full = 1'b1;
                push_slot = '0;
            end
        endcase
    end

    always_comb
    begin
        unique case (pop_q)
            tlfs_pkg::Q_HIGH: pop_slot = head_reg[0];
            tlfs_pkg::Q_LOW:  pop_slot = head_reg[1];
            tlfs_pkg::Q_WAIT: pop_slot = head_reg[2];
            default:          pop_slot = '0;
        endcase
    end

    assign push_ok = push_en && !push_full;

    // Head / count update
    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            count_next[q] = count_reg[q];
            head_next[q]  = head_reg[q];
            if (push_ok && (push_q == 2'(q)))
                count_next[q] = count_next[q] + 1'b1;
            if (pop_en && (pop_q == 2'(q)))
            begin
                count_next[q] = count_next[q] - 1'b1;
                head_next[q]  = (head_reg[q] == LAST_SLOT) ? '0 : head_reg[q] + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        idle_next    = idle_reg;
        all_next     = all_reg;
        push_en      = 1'b0;
        push_q       = tlfs_pkg::Q_HIGH;
        push_id      = '0;
        pop_en       = 1'b0;
        pop_q        = tlfs_pkg::Q_HIGH;
        thr_we       = 1'b0;
        thr_waddr    = run_idx;
        thr_wdata    = '0;
        load_out     = 1'b0;

        unique case (state_reg)
            tlfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tlfs_pkg::ST_REPORT;
                    unique case (in_func)
                        tlfs_pkg::FN_ADD_READY:
                        begin
                            if (tid_ok)
                            begin
                                thr_we    = 1'b1;
                                thr_waddr = IW'(in_tid);
                                thr_wdata = {{SW{1'b0}}, first_reg};
                                push_en   = 1'b1;
                                push_q    = tlfs_pkg::Q_HIGH;
                                push_id   = in_tid;
                            end
                        end
                        tlfs_pkg::FN_FINISHED:
                            state_next = tlfs_pkg::ST_DISP;
                        tlfs_pkg::FN_BLOCKED:
                        begin
                            if (!idle_reg)
                            begin
                                push_en    = 1'b1;
                                push_q     = tlfs_pkg::Q_WAIT;
                                push_id    = running_reg;
                                state_next = tlfs_pkg::ST_DISP;
                            end
                        end
                        tlfs_pkg::FN_NOTIFY_ONE, tlfs_pkg::FN_NOTIFY_ALL:
                        begin
                            if (count_reg[tlfs_pkg::Q_WAIT] != '0)
                            begin
                                pop_en     = 1'b1;
                                pop_q      = tlfs_pkg::Q_WAIT;
                                all_next   = (in_func == tlfs_pkg::FN_NOTIFY_ALL);
                                state_next = tlfs_pkg::ST_WAITRD;
                            end
                        end
                        tlfs_pkg::FN_TICK:
                            state_next = idle_reg ? tlfs_pkg::ST_DISP : tlfs_pkg::ST_THR;
                        default:
                            state_next = tlfs_pkg::ST_REPORT;
                    endcase
                end
            end

            tlfs_pkg::ST_DISP:
            begin
                if (count_reg[tlfs_pkg::Q_HIGH] != '0)
                begin
                    pop_en     = 1'b1;
                    pop_q      = tlfs_pkg::Q_HIGH;
                    state_next = tlfs_pkg::ST_POP;
                end
                else if (count_reg[tlfs_pkg::Q_LOW] != '0)
                begin
                    pop_en     = 1'b1;
                    pop_q      = tlfs_pkg::Q_LOW;
                    state_next = tlfs_pkg::ST_POP;
                end
                else
                begin
                    running_next = '0;
                    idle_next    = 1'b1;
                    state_next   = tlfs_pkg::ST_REPORT;
                end
            end

            tlfs_pkg::ST_POP:
            begin
                running_next = fifo_rdata_reg;
                idle_next    = 1'b0;
                state_next   = tlfs_pkg::ST_REPORT;
            end

            tlfs_pkg::ST_WAITRD:
            begin
                if (wait_id_ok)
                begin
                    thr_we    = 1'b1;
                    thr_waddr = IW'(fifo_rdata_reg);
                    thr_wdata = {{SW{1'b0}}, first_reg};
                    push_en   = 1'b1;
                    push_q    = tlfs_pkg::Q_HIGH;
                    push_id   = fifo_rdata_reg;
                end
                // next blocked thread read overlaps this one's push
                if (all_reg && (count_reg[tlfs_pkg::Q_WAIT] != '0))
                begin
                    pop_en = 1'b1;
                    pop_q  = tlfs_pkg::Q_WAIT;
                end
                else
                    state_next = tlfs_pkg::ST_REPORT;
            end

            tlfs_pkg::ST_THR:
            begin
                thr_we = 1'b1;
                if ((thr_limit == second_reg) && (count_reg[tlfs_pkg::Q_HIGH] != '0))
                begin
                    // low-level thread preempted by waiting high work
                    thr_wdata  = {{SW{1'b0}}, thr_limit};
                    push_en    = 1'b1;
                    push_q     = tlfs_pkg::Q_LOW;
                    push_id    = running_reg;
                    pop_en     = 1'b1;
                    pop_q      = tlfs_pkg::Q_HIGH;
                    state_next = tlfs_pkg::ST_POP;
                end
                else if (tick_sum < {1'b0, thr_limit})
                begin
                    thr_wdata  = {tick_sum[SW-1:0], thr_limit};
                    state_next = tlfs_pkg::ST_REPORT;
                end
                else
                begin
                    // slice used up: demote, dispatch after the push lands
                    thr_wdata  = {{SW{1'b0}}, second_reg};
                    push_en    = 1'b1;
                    push_q     = tlfs_pkg::Q_LOW;
                    push_id    = running_reg;
                    state_next = tlfs_pkg::ST_DISP;
                end
            end

            tlfs_pkg::ST_REPORT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = tlfs_pkg::ST_IDLE;
                end
            end

            default:
                state_next = tlfs_pkg::ST_IDLE;
        endcase
    end

    // overflow flag covers the whole transaction
    assign ovf_next = (accept ? 1'b0 : ovf_reg) | (push_en && push_full);

    assign m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tlfs_pkg::ST_IDLE;
            running_reg  <= '0;
            idle_reg     <= 1'b1;
            ovf_reg      <= 1'b0;
            all_reg      <= 1'b0;
            first_reg    <= '0;
            second_reg   <= '0;
            inc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int q = 0; q < 3; q++)
            begin
                head_reg[q]  <= '0;
                count_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            idle_reg     <= idle_next;
            ovf_reg      <= ovf_next;
            all_reg      <= all_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int q = 0; q < 3; q++)
            begin
                head_reg[q]  <= head_next[q];
                count_reg[q] <= count_next[q];
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (tlfs_pkg::cfg_idx_t'(cfg_index))
                    tlfs_pkg::CFG_FIRST_SLICE:  first_reg  <= cfg_data;
                    tlfs_pkg::CFG_SECOND_SLICE: second_reg <= cfg_data;
                    tlfs_pkg::CFG_TICK_INC:     inc_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
            m_tdata_reg <= {2'b00, ovf_reg, idle_reg, idle_reg ? 4'd0 : running_reg};
    end

    // FIFO memory: one write, one read per cycle
    always_ff @(posedge clk)
    begin
        if (push_ok)
            fifo_mem[{push_q, push_slot}] <= push_id;
        fifo_rdata_reg <= fifo_mem[{pop_q, pop_slot}];
    end

    // Thread memory: {elapsed, limit}
    always_ff @(posedge clk)
    begin
        if (thr_we)
            thr_mem[thr_waddr] <= thr_wdata;
        thr_rdata_reg <= thr_mem[run_idx];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= FULL_CNT) && (count_reg[1] <= FULL_CNT) &&
        (count_reg[2] <= FULL_CNT))
        else $error("FIFO fill count beyond depth");

    a_push_pop_split: assert property (@(posedge clk) disable iff (!rst_n)
        (push_en && pop_en) |-> (push_q != pop_q))
        else $error("push and pop on the same queue in one cycle");

    a_pop_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlfs_pkg::ST_POP) |->
        ($past(state_reg) == tlfs_pkg::ST_DISP || $past(state_reg) == tlfs_pkg::ST_THR))
        else $error("pop result taken without a preceding read");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[4]) |-> (m_tdata_reg[3:0] == 4'd0))
        else $error("idle result carries a thread id");

    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_en && pop_q == tlfs_pkg::Q_WAIT) |-> (count_reg[2] != '0))
        else $error("pop from empty blocked FIFO");

endmodule
